FILE: sv/vertex_view_projection_assert.svh
// Assertion helpers shared by the vertex projection block.
`ifndef VERTEX_VIEW_PROJECTION_ASSERT_SVH
`define VERTEX_VIEW_PROJECTION_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define VVP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("vertex_view_projection: check failed");

// Property checked on every clock edge, reset included.
`define VVP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("vertex_view_projection: check failed");

`endif

FILE: sv/vvp_pkg.sv
// ----------------------------------------------------------------------------
// vvp_pkg: shared types and helpers of the vertex projection block
// Word layouts, configuration register set and saturation helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vvp_pkg;

    localparam int DivSteps = 64;
    localparam int QDepth   = 4;
    localparam int QPtrW    = 2;
    localparam int QCntW    = 3;

    localparam logic signed [63:0] Max32 = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] Min32 = 64'shFFFF_FFFF_8000_0000;

    typedef enum logic [2:0] {
        CFG_ROW_X,
        CFG_ROW_Y,
        CFG_ROW_Z,
        CFG_TRANS,
        CFG_DIST,
        CFG_ASPECT,
        CFG_WIDTH,
        CFG_HEIGHT
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic signed [31:0] camera_depth;
        logic               clipped_flag;
    } t_out;

    typedef struct packed {
        logic [47:0] row_x;
        logic [47:0] row_y;
        logic [47:0] row_z;
        logic [47:0] trans;
        logic [31:0] distance;
        logic [15:0] aspect;
        logic [12:0] width;
        logic [12:0] height;
    } t_cfg;

    // Camera-space word handed from the front to the back.
    typedef struct packed {
        logic signed [31:0] xc;
        logic signed [31:0] yc;
        logic signed [31:0] zc;
        logic               flag;
    } t_cam;

    // Sideband that rides along the divider.
    typedef struct packed {
        logic               neg_x;
        logic               neg_y;
        logic               zero_x;
        logic               zero_y;
        logic               den_zero;
        logic               flag;
        logic signed [31:0] zc;
    } t_side;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic signed [31:0] val;
        logic               ovf;
    } t_sat;

    function automatic t_sat sat32(input logic signed [63:0] v);
        t_sat r;
        if (v > Max32) begin
            r.val = 32'sh7FFF_FFFF;
            r.ovf = 1'b1;
        end else if (v < Min32) begin
            r.val = 32'sh8000_0000;
            r.ovf = 1'b1;
        end else begin
            r.val = v[31:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: sv/vvp_front.sv
// ----------------------------------------------------------------------------
// vvp_front: world-to-camera matrix stage
// Three pipeline stages: products, sum with rounding, saturation and negation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vvp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  vvp_pkg::t_in  i_data,
    input  vvp_pkg::t_cfg i_cfg,
    input  logic          i_full,
    output logic          o_push,
    output vvp_pkg::t_cam o_cam
);
    import vvp_pkg::*;

    logic               fe;
    logic signed [31:0] w [0:2];
    logic        [47:0] rows [0:2];
    logic signed [47:0] n1_p [0:2][0:2];
    logic signed [47:0] r1_p [0:2][0:2];
    logic signed [49:0] n2_acc [0:2];
    logic signed [49:0] r2_acc [0:2];
    logic               r1_v, r2_v, r3_v;
    t_cam               n3_cam, r3_cam;
    t_sat               s [0:2];

    assign fe      = !r3_v || !i_full;
    assign o_ready = fe;
    assign o_push  = r3_v && !i_full;
    assign o_cam   = r3_cam;

    always_comb begin
        w[0]    = i_data.world_x;
        w[1]    = i_data.world_y;
        w[2]    = i_data.world_z;
        rows[0] = i_cfg.row_x;
        rows[1] = i_cfg.row_y;
        rows[2] = i_cfg.row_z;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                n1_p[k][j] = w[j] * $signed(rows[j][16*k +: 16]);
            end
        end
    end

    // The offset is an integer, so it sits 28 bits up in the exact sum.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n2_acc[k] = 50'(r1_p[k][0]) + 50'(r1_p[k][1]) + 50'(r1_p[k][2])
                      + $signed({{6{i_cfg.trans[16*k+15]}}, i_cfg.trans[16*k +: 16], 28'b0})
                      + 50'sd2048;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s[k] = sat32(64'(r2_acc[k] >>> 12));
        end
        n3_cam.flag = s[0].ovf || s[1].ovf || s[2].ovf;
        if (s[0].val == 32'sh8000_0000) begin
            n3_cam.xc   = 32'sh7FFF_FFFF;
            n3_cam.flag = 1'b1;
        end else begin
            n3_cam.xc = -s[0].val;
        end
        n3_cam.yc = s[1].val;
        n3_cam.zc = s[2].val;
        if (s[2].val == 32'sd0) begin
            n3_cam.flag = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (fe) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
        if (fe) begin
            r1_p   <= n1_p;
            r2_acc <= n2_acc;
            r3_cam <= n3_cam;
        end
    end

endmodule

FILE: sv/vvp_queue.sv
// ----------------------------------------------------------------------------
// vvp_queue: short queue between the matrix front and the projection back
// Four entries of camera-space words, first in first out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vvp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  vvp_pkg::t_cam    i_data,
    input  logic             i_pop,
    output vvp_pkg::t_cam    o_data,
    output vvp_pkg::t_q_stat o_stat
);
    import vvp_pkg::*;

    t_cam             r_mem [0:QDepth-1];
    logic [QPtrW-1:0] r_wr, r_rd;
    logic [QCntW-1:0] r_cnt;

    assign o_stat.full  = (r_cnt == QCntW'(QDepth));
    assign o_stat.empty = (r_cnt == '0);
    assign o_data       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: sv/vvp_div.sv
// ----------------------------------------------------------------------------
// vvp_div: pipelined restoring divider, two numerators over one divisor
// One quotient bit per stage; the sideband word travels with each item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vvp_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [63:0]    i_num_x,
    input  logic [63:0]    i_num_y,
    input  logic [31:0]    i_den,
    input  vvp_pkg::t_side i_side,
    output logic           o_valid,
    output logic [63:0]    o_q_x,
    output logic [63:0]    o_q_y,
    output vvp_pkg::t_side o_side
);
    import vvp_pkg::*;

    // The dividend shifts out at the top while quotient bits shift in below.
    logic        c_v    [0:DivSteps];
    logic [31:0] c_rx   [0:DivSteps];
    logic [31:0] c_ry   [0:DivSteps];
    logic [63:0] c_dx   [0:DivSteps];
    logic [63:0] c_dy   [0:DivSteps];
    logic [31:0] c_den  [0:DivSteps];
    t_side       c_side [0:DivSteps];

    logic        r_v    [1:DivSteps];
    logic [31:0] r_rx   [1:DivSteps];
    logic [31:0] r_ry   [1:DivSteps];
    logic [63:0] r_dx   [1:DivSteps];
    logic [63:0] r_dy   [1:DivSteps];
    logic [31:0] r_den  [1:DivSteps];
    t_side       r_side [1:DivSteps];

    assign c_v[0]    = i_valid;
    assign c_rx[0]   = '0;
    assign c_ry[0]   = '0;
    assign c_dx[0]   = i_num_x;
    assign c_dy[0]   = i_num_y;
    assign c_den[0]  = i_den;
    assign c_side[0] = i_side;

    for (genvar k = 1; k <= DivSteps; k++) begin : g_step
        logic [32:0] t_x, t_y;
        logic        ge_x, ge_y;

        assign c_v[k]    = r_v[k];
        assign c_rx[k]   = r_rx[k];
        assign c_ry[k]   = r_ry[k];
        assign c_dx[k]   = r_dx[k];
        assign c_dy[k]   = r_dy[k];
        assign c_den[k]  = r_den[k];
        assign c_side[k] = r_side[k];

        assign t_x  = {c_rx[k-1], c_dx[k-1][63]};
        assign t_y  = {c_ry[k-1], c_dy[k-1][63]};
        assign ge_x = (t_x >= {1'b0, c_den[k-1]});
        assign ge_y = (t_y >= {1'b0, c_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= c_v[k-1];
            end
            if (i_en) begin
                r_rx[k]   <= ge_x ? 32'(t_x - {1'b0, c_den[k-1]}) : t_x[31:0];
                r_ry[k]   <= ge_y ? 32'(t_y - {1'b0, c_den[k-1]}) : t_y[31:0];
                r_dx[k]   <= {c_dx[k-1][62:0], ge_x};
                r_dy[k]   <= {c_dy[k-1][62:0], ge_y};
                r_den[k]  <= c_den[k-1];
                r_side[k] <= c_side[k-1];
            end
        end
    end

    assign o_valid = c_v[DivSteps];
    assign o_q_x   = c_dx[DivSteps];
    assign o_q_y   = c_dy[DivSteps];
    assign o_side  = c_side[DivSteps];

endmodule

FILE: sv/vvp_back.sv
// ----------------------------------------------------------------------------
// vvp_back: perspective divide and viewport map
// Magnitudes, products with the view distance, the divider, aspect scaling,
// viewport products and final saturation into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vvp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vvp_pkg::t_cfg    i_cfg,
    input  vvp_pkg::t_cam    i_cam,
    input  vvp_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output vvp_pkg::t_out    o_data
);
    import vvp_pkg::*;

    logic               be;
    logic               r0_v, r1_v, r2_v, r3_v, r4_v, r_out_v;
    logic        [31:0] r0_an_x, r0_an_y, r0_ad;
    logic               r0_neg_x, r0_neg_y, r0_flag;
    logic signed [31:0] r0_zc;
    logic        [63:0] r1_prod_x, r1_prod_y;
    logic        [31:0] r1_ad;
    t_side              r1_side;
    logic               d_v;
    logic        [63:0] d_q_x, d_q_y;
    t_side              d_side;

    logic signed [31:0] n2_px, n2_py, r2_px, r2_py;
    logic               n2_flag, n2_py_done;
    logic               r2_flag, r2_py_done, r2_neg_y;
    logic        [63:0] r2_pa;
    logic signed [31:0] r2_zc;

    logic        [51:0] qa;
    logic signed [31:0] n3_py, r3_px, r3_py, r3_zc;
    logic               n3_flag, r3_flag;

    logic signed [47:0] r4_vx, r4_vy;
    logic signed [31:0] r4_zc;
    logic               r4_flag;
    t_sat               s_x, s_y;
    t_out               r_out;

    assign be      = !r_out_v || i_ready;
    assign o_pop   = be && !i_q_stat.empty;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    vvp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (be),
        .i_valid (r1_v),
        .i_num_x (r1_prod_x),
        .i_num_y (r1_prod_y),
        .i_den   (r1_ad),
        .i_side  (r1_side),
        .o_valid (d_v),
        .o_q_x   (d_q_x),
        .o_q_y   (d_q_y),
        .o_side  (d_side)
    );

    // An x quotient at or above 2^31 clamps there before the sign is applied; a y quotient clamps at 2^48.
    always_comb begin
        n2_flag    = d_side.flag;
        n2_py_done = 1'b1;
        n2_py      = '0;
        if (d_side.zero_x) begin
            n2_px = '0;
        end else if (d_side.den_zero || (|d_q_x[63:31])) begin
            n2_px   = d_side.neg_x ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            n2_flag = n2_flag || d_side.den_zero || !d_side.neg_x;
        end else begin
            n2_px = d_side.neg_x ? -$signed({1'b0, d_q_x[30:0]})
                                 : $signed({1'b0, d_q_x[30:0]});
        end
        if (d_side.zero_y) begin
            n2_py = '0;
        end else if (d_side.den_zero || (|d_q_y[63:48])) begin
            n2_py   = d_side.neg_y ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            n2_flag = 1'b1;
        end else begin
            n2_py_done = 1'b0;
        end
    end

    always_comb begin
        qa      = 52'(r2_pa >> 12);
        n3_flag = r2_flag;
        n3_py   = r2_py;
        if (!r2_py_done) begin
            if (|qa[51:31]) begin
                n3_py   = r2_neg_y ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                n3_flag = n3_flag || !r2_neg_y;
            end else begin
                n3_py = r2_neg_y ? -$signed({1'b0, qa[30:0]})
                                 : $signed({1'b0, qa[30:0]});
            end
        end
    end

    always_comb begin
        s_x = sat32(64'(r4_vx >>> 1));
        s_y = sat32(64'(r4_vy >>> 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v    <= 1'b0;
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (be) begin
            r0_v    <= o_pop;
            r1_v    <= r0_v;
            r2_v    <= d_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r_out_v <= r4_v;
        end
        if (be) begin
            r0_an_x  <= i_cam.xc[31] ? 32'(-i_cam.xc) : i_cam.xc;
            r0_an_y  <= i_cam.yc[31] ? 32'(-i_cam.yc) : i_cam.yc;
            r0_ad    <= i_cam.zc[31] ? 32'(-i_cam.zc) : i_cam.zc;
            r0_neg_x <= i_cam.xc[31] != i_cam.zc[31];
            r0_neg_y <= i_cam.yc[31] != i_cam.zc[31];
            r0_flag  <= i_cam.flag;
            r0_zc    <= i_cam.zc;

            r1_prod_x         <= r0_an_x * i_cfg.distance;
            r1_prod_y         <= r0_an_y * i_cfg.distance;
            r1_ad             <= r0_ad;
            r1_side.neg_x     <= r0_neg_x;
            r1_side.neg_y     <= r0_neg_y;
            r1_side.zero_x    <= (r0_an_x == '0) || (i_cfg.distance == '0);
            r1_side.zero_y    <= (r0_an_y == '0) || (i_cfg.distance == '0)
                                 || (i_cfg.aspect == '0);
            r1_side.den_zero  <= (r0_ad == '0);
            r1_side.flag      <= r0_flag;
            r1_side.zc        <= r0_zc;

            r2_px      <= n2_px;
            r2_py      <= n2_py;
            r2_flag    <= n2_flag;
            r2_py_done <= n2_py_done;
            r2_neg_y   <= d_side.neg_y;
            r2_pa      <= d_q_y[47:0] * i_cfg.aspect;
            r2_zc      <= d_side.zc;

            r3_px   <= r2_px;
            r3_py   <= n3_py;
            r3_flag <= n3_flag;
            r3_zc   <= r2_zc;

            r4_vx   <= ($signed({1'b0, i_cfg.width}) - 14'sd1)
                       * ($signed({{2{r3_px[31]}}, r3_px}) + 34'sd65536);
            r4_vy   <= ($signed({1'b0, i_cfg.height}) - 14'sd1)
                       * (34'sd65536 - $signed({{2{r3_py[31]}}, r3_py}));
            r4_flag <= r3_flag;
            r4_zc   <= r3_zc;

            r_out.screen_x     <= s_x.val;
            r_out.screen_y     <= s_y.val;
            r_out.camera_depth <= r4_zc;
            r_out.clipped_flag <= r4_flag || s_x.ovf || s_y.ovf;
        end
    end

endmodule

FILE: sv/vertex_view_projection.sv
// ----------------------------------------------------------------------------
// vertex_view_projection: world vertex to viewport transform
// Configuration registers, matrix front, queue and projection back.
// ----------------------------------------------------------------------------
// The block takes one vertex word per clock and gives one result word per
// clock when neither side stalls. A vertex passes through the matrix
// pipeline and the four-word queue, and then through the back end, whose
// length is set by the 64-stage pipelined divider that works out both
// projected coordinates against the common camera depth. The front keeps
// accepting words while the back stalls until the queue fills.
`timescale 1ns / 1ps

module vertex_view_projection (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  vvp_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output vvp_pkg::t_out o_data,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [47:0]   i_cfg_data
);
    import vvp_pkg::*;

    t_cfg    r_cfg;
    logic    f_push, q_pop;
    t_cam    f_cam, q_cam;
    t_q_stat q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_x    <= 48'h0000_0000_1000;
            r_cfg.row_y    <= 48'h0000_1000_0000;
            r_cfg.row_z    <= 48'h1000_0000_0000;
            r_cfg.trans    <= '0;
            r_cfg.distance <= 32'h0001_0000;
            r_cfg.aspect   <= 16'h1000;
            r_cfg.width    <= 13'd640;
            r_cfg.height   <= 13'd480;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ROW_X:  r_cfg.row_x    <= i_cfg_data;
                CFG_ROW_Y:  r_cfg.row_y    <= i_cfg_data;
                CFG_ROW_Z:  r_cfg.row_z    <= i_cfg_data;
                CFG_TRANS:  r_cfg.trans    <= i_cfg_data;
                CFG_DIST:   r_cfg.distance <= i_cfg_data[31:0];
                CFG_ASPECT: r_cfg.aspect   <= i_cfg_data[15:0];
                CFG_WIDTH:  r_cfg.width    <= i_cfg_data[12:0];
                CFG_HEIGHT: r_cfg.height   <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    vvp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_cfg   (r_cfg),
        .i_full  (q_stat.full),
        .o_push  (f_push),
        .o_cam   (f_cam)
    );

    vvp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_cam),
        .i_pop   (q_pop),
        .o_data  (q_cam),
        .o_stat  (q_stat)
    );

    vvp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cam    (q_cam),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data)
    );

`include "vertex_view_projection_assert.svh"

    // A zero camera depth always marks the word as clipped.
    `VVP_ASSERT(a_zero_depth_clipped, o_valid && (o_data.camera_depth == 32'sd0) |-> o_data.clipped_flag)
    // The queue cannot report full and empty at once.
    `VVP_ASSERT(a_queue_status, !(q_stat.full && q_stat.empty))
    // A word is never popped from an empty queue.
    `VVP_ASSERT(a_no_underflow, q_stat.empty |-> !q_pop)
    // No result word is shown in the cycle after reset.
    `VVP_ASSERT_ALWAYS(a_reset_idle, !$past(i_rst_n) |-> !o_valid)

endmodule
